### sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/hc_pkg.sv
package hc_pkg;

  // code geometry
  localparam int unsigned MaxN  = 31;
  localparam int unsigned MaxK  = 26;
  localparam int unsigned SynW  = 5;
  localparam int unsigned N7    = 7;
  localparam int unsigned K7    = 4;
  localparam int unsigned N15   = 15;
  localparam int unsigned K15   = 11;
  localparam int unsigned N31   = 31;
  localparam int unsigned K31   = 26;

  // request command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [1:0] {
    CODE_7_4   = 2'd0,
    CODE_15_11 = 2'd1,
    CODE_31_26 = 2'd2
  } code_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] operand;
  } in_t;

  typedef struct packed {
    logic [30:0] result_word;
    logic        range_error;
  } out_t;

  // after placement: bit p-1 holds codeword position p
  typedef struct packed {
    logic             cmd;
    code_e            code;
    logic             err;
    logic [MaxN-1:0]  pos;
  } place_t;

  typedef struct packed {
    logic             cmd;
    code_e            code;
    logic             err;
    logic [MaxN-1:0]  pos;
    logic [SynW-1:0]  syn;
  } synd_t;

  // unused select value saturates to the longest code
  function automatic code_e code_of(logic [1:0] sel);
    code_e c;
    unique case (sel)
      2'd0:    c = CODE_7_4;
      2'd1:    c = CODE_15_11;
      default: c = CODE_31_26;
    endcase
    return c;
  endfunction

  function automatic bit is_pow2(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // rank of position p among the data positions, from 0
  function automatic int data_idx(int p);
    int cnt;
    cnt = 0;
    for (int j = 0; j < SynW; j++) begin
      if ((1 << j) <= p) cnt++;
    end
    return p - 1 - cnt;
  endfunction

  // scatter data bits onto the data positions, msb first
  function automatic logic [MaxN-1:0] place_data(logic [MaxK-1:0] d, int n, int k);
    logic [MaxN-1:0] pos;
    pos = '0;
    for (int p = 1; p <= MaxN; p++) begin
      if (p <= n && !is_pow2(p) && (k - 1 - data_idx(p)) >= 0) begin
        pos[p-1] = d[k-1-data_idx(p)];
      end
    end
    return pos;
  endfunction

  // received word to positions, position 1 is the msb
  function automatic logic [MaxN-1:0] word_to_pos(logic [MaxN-1:0] w, int n);
    logic [MaxN-1:0] pos;
    pos = '0;
    for (int p = 1; p <= MaxN; p++) begin
      if (p <= n) pos[p-1] = w[n-p];
    end
    return pos;
  endfunction

  function automatic logic [MaxN-1:0] pos_to_word(logic [MaxN-1:0] pos, int n);
    logic [MaxN-1:0] w;
    w = '0;
    for (int p = 1; p <= MaxN; p++) begin
      if (p <= n) w[n-p] = pos[p-1];
    end
    return w;
  endfunction

  // gather the data positions back into a data word
  function automatic logic [MaxK-1:0] extract_data(logic [MaxN-1:0] pos, int n, int k);
    logic [MaxK-1:0] d;
    d = '0;
    for (int p = 1; p <= MaxN; p++) begin
      if (p <= n && !is_pow2(p) && (k - 1 - data_idx(p)) >= 0) begin
        d[k-1-data_idx(p)] = pos[p-1];
      end
    end
    return d;
  endfunction

endpackage

### sv/hamming_codec_7_15_31.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-----------------------------
// cfg       | in        | cfg_we_i                   | cfg_wdata_i (code select)
// request   | in        | in_valid_i / in_ready_o    | in_data_i (cmd, operand)
// result    | out       | out_valid_o / out_ready_i  | out_data_o (word, range err)
//
// three register stages: placement, syndrome tree, correction and output
// register. an accepted request passes the placement, syndrome and output registers in turn.
// one request per cycle sustained while the output is not held; the stage valid chain sets the rate.
// reset clears the stage valid bits and sets code select to (7,4).
// a stalled output only blocks the input once every stage holds a request.
module hamming_codec_7_15_31 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  hc_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output hc_pkg::out_t out_data_o
);

  `include "assert_macros.svh"

  logic [1:0]     code_sel_q;
  logic           s1_valid, s1_ready;
  hc_pkg::place_t s1_data;
  logic           s2_valid, s2_ready;
  hc_pkg::synd_t  s2_data;

  // code select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_sel_q <= 2'd0;
    end else if (cfg_we_i) begin
      code_sel_q <= cfg_wdata_i;
    end
  end

  // stage 1: range check and placement
  hc_place u_place (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .code_sel_i (code_sel_q),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .data_i     (in_data_i),
    .valid_o    (s1_valid),
    .ready_i    (s1_ready),
    .data_o     (s1_data)
  );

  // stage 2: syndrome
  hc_syndrome u_syndrome (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // stage 3: parity fill or correction, output register
  hc_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // a range error always carries a zero word
  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.range_error, out_data_o.result_word == '0)
  // input only stalls when the whole pipe is full and the output is held
  `ASSERT_IMPLIES(a_stall_src, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  // the syndrome stage only stalls while the output register holds a result
  `ASSERT_ALWAYS(a_fill_order, clk_i, rst_ni, !(s2_valid && !s2_ready) || out_valid_o)

endmodule

### sv/hc_place.sv
module hc_place (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     code_sel_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  hc_pkg::in_t    data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hc_pkg::place_t data_o
);

  logic           valid_q;
  hc_pkg::place_t data_d, data_q;

  // range check and placement of operand bits onto positions
  always_comb begin
    data_d      = '0;
    data_d.cmd  = data_i.cmd;
    data_d.code = hc_pkg::code_of(code_sel_i);
    unique case (data_d.code)
      hc_pkg::CODE_7_4: begin
        if (data_i.cmd == hc_pkg::CMD_DECODE) begin
          data_d.err = |data_i.operand[31:hc_pkg::N7];
          data_d.pos = hc_pkg::word_to_pos(data_i.operand[hc_pkg::MaxN-1:0], hc_pkg::N7);
        end else begin
          data_d.err = |data_i.operand[31:hc_pkg::K7];
          data_d.pos = hc_pkg::place_data(data_i.operand[hc_pkg::MaxK-1:0],
                                          hc_pkg::N7, hc_pkg::K7);
        end
      end
      hc_pkg::CODE_15_11: begin
        if (data_i.cmd == hc_pkg::CMD_DECODE) begin
          data_d.err = |data_i.operand[31:hc_pkg::N15];
          data_d.pos = hc_pkg::word_to_pos(data_i.operand[hc_pkg::MaxN-1:0], hc_pkg::N15);
        end else begin
          data_d.err = |data_i.operand[31:hc_pkg::K15];
          data_d.pos = hc_pkg::place_data(data_i.operand[hc_pkg::MaxK-1:0],
                                          hc_pkg::N15, hc_pkg::K15);
        end
      end
      default: begin
        if (data_i.cmd == hc_pkg::CMD_DECODE) begin
          data_d.err = data_i.operand[31];
          data_d.pos = hc_pkg::word_to_pos(data_i.operand[hc_pkg::MaxN-1:0], hc_pkg::N31);
        end else begin
          data_d.err = |data_i.operand[31:hc_pkg::K31];
          data_d.pos = hc_pkg::place_data(data_i.operand[hc_pkg::MaxK-1:0],
                                          hc_pkg::N31, hc_pkg::K31);
        end
      end
    endcase
  end

  // stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/hc_syndrome.sv
module hc_syndrome (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  hc_pkg::place_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hc_pkg::synd_t  data_o
);

  logic                        valid_q;
  hc_pkg::synd_t               data_d, data_q;
  logic [hc_pkg::SynW-1:0]     syn;

  // xor of the indices of all set positions
  always_comb begin
    syn = '0;
    for (int p = 1; p <= hc_pkg::MaxN; p++) begin
      if (data_i.pos[p-1]) syn = syn ^ hc_pkg::SynW'(p);
    end
  end

  always_comb begin
    data_d.cmd  = data_i.cmd;
    data_d.code = data_i.code;
    data_d.err  = data_i.err;
    data_d.pos  = data_i.pos;
    data_d.syn  = syn;
  end

  // stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/hc_finish.sv
module hc_finish (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hc_pkg::synd_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hc_pkg::out_t  data_o
);

  logic                    valid_q;
  hc_pkg::out_t            data_d, data_q;
  logic [hc_pkg::MaxN-1:0] pos_fix;
  logic [hc_pkg::MaxN-1:0] word;
  logic [hc_pkg::MaxK-1:0] dword;

  // encode fills parity positions, decode flips the named position
  always_comb begin
    pos_fix = data_i.pos;
    if (data_i.cmd == hc_pkg::CMD_DECODE) begin
      if (data_i.syn != '0) begin
        pos_fix = data_i.pos ^ (hc_pkg::MaxN'(1) << (data_i.syn - hc_pkg::SynW'(1)));
      end
    end else begin
      for (int j = 0; j < hc_pkg::SynW; j++) begin
        pos_fix[(1 << j) - 1] = data_i.syn[j];
      end
    end
  end

  // codeword and data views per code length
  always_comb begin
    unique case (data_i.code)
      hc_pkg::CODE_7_4: begin
        word  = hc_pkg::pos_to_word(pos_fix, hc_pkg::N7);
        dword = hc_pkg::extract_data(pos_fix, hc_pkg::N7, hc_pkg::K7);
      end
      hc_pkg::CODE_15_11: begin
        word  = hc_pkg::pos_to_word(pos_fix, hc_pkg::N15);
        dword = hc_pkg::extract_data(pos_fix, hc_pkg::N15, hc_pkg::K15);
      end
      default: begin
        word  = hc_pkg::pos_to_word(pos_fix, hc_pkg::N31);
        dword = hc_pkg::extract_data(pos_fix, hc_pkg::N31, hc_pkg::K31);
      end
    endcase
  end

  // result select, zero on range error
  always_comb begin
    data_d.range_error = data_i.err;
    if (data_i.err) begin
      data_d.result_word = '0;
    end else if (data_i.cmd == hc_pkg::CMD_DECODE) begin
      data_d.result_word = 31'(dword);
    end else begin
      data_d.result_word = word;
    end
  end

  // output register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### tb/sv/hamming_codec_7_15_31_tb.sv
module hamming_codec_7_15_31_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CODE_SEL_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT     = 200_000;
  localparam int         NUM_PHASES      = 7;
  localparam int         TAIL_CYCLES     = 8;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         cfg_we_i    = 1'b0;
  logic [1:0]   cfg_wdata_i = hc_pkg::CODE_7_4;
  logic         in_valid_i  = 1'b0;
  logic         in_ready_o;
  hc_pkg::in_t  in_data_i   = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  hc_pkg::out_t out_data_o;

  // testbench copy of the code select register
  logic [1:0] active_sel = hc_pkg::CODE_7_4;

  hc_pkg::in_t  request_q[$];
  hc_pkg::out_t predicted_words[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_gap       = 0;
  int stall_left     = 0;
  int gap_pct        = 0;
  int stall_pct      = 0;
  int queued_count   = 0;
  int checked_count  = 0;

  hamming_codec_7_15_31 u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // code length and data width for a select value, unused value saturates
  function automatic void code_geometry(input logic [1:0] sel, output int n, output int k);
    case (sel)
      hc_pkg::CODE_7_4: begin
        n = hc_pkg::N7;
        k = hc_pkg::K7;
      end
      hc_pkg::CODE_15_11: begin
        n = hc_pkg::N15;
        k = hc_pkg::K15;
      end
      default: begin
        n = hc_pkg::N31;
        k = hc_pkg::K31;
      end
    endcase
  endfunction

  function automatic bit parity_slot(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // xor of the indexes of all set positions, position 1 is the msb
  function automatic logic [4:0] position_syndrome(logic [31:0] word, int n);
    logic [4:0] syn;
    syn = '0;
    for (int p = 1; p <= n; p++) begin
      if (word[n-p]) syn ^= p[4:0];
    end
    return syn;
  endfunction

  // expected codec answer for one request under a given code select
  function automatic hc_pkg::out_t hamming_predict(hc_pkg::in_t req, logic [1:0] sel);
    hc_pkg::out_t res;
    int           n, k, d;
    logic [31:0]  word;
    logic [4:0]   syn;
    logic [25:0]  data;
    res  = '0;
    word = '0;
    data = '0;
    code_geometry(sel, n, k);
    if (req.cmd == hc_pkg::CMD_ENCODE) begin
      if ((req.operand >> k) != 0) begin
        res.range_error = 1'b1;
      end else begin
        // data bits onto non-parity positions, msb first
        d = k;
        for (int p = 1; p <= n; p++) begin
          if (!parity_slot(p)) begin
            d--;
            word[n-p] = req.operand[d];
          end
        end
        syn = position_syndrome(word, n);
        for (int j = 0; (1 << j) <= n; j++) word[n-(1<<j)] = syn[j];
        res.result_word = word[30:0];
      end
    end else begin
      if ((req.operand >> n) != 0) begin
        res.range_error = 1'b1;
      end else begin
        // correct the named position, then gather the data bits
        word = req.operand;
        syn  = position_syndrome(word, n);
        if (syn != '0) word[n-int'(syn)] = ~word[n-int'(syn)];
        for (int p = 1; p <= n; p++) begin
          if (!parity_slot(p)) data = {data[24:0], word[n-p]};
        end
        res.result_word = 31'(data);
      end
    end
    return res;
  endfunction

  task automatic queue_request(logic cmd, logic [31:0] operand);
    hc_pkg::in_t req;
    req.cmd     = cmd;
    req.operand = operand;
    request_q.push_back(req);
    queued_count++;
  endtask

  // codeword for a data word under the active code
  function automatic logic [31:0] codeword_of(logic [31:0] data);
    hc_pkg::in_t  req;
    hc_pkg::out_t res;
    req.cmd     = hc_pkg::CMD_ENCODE;
    req.operand = data;
    res         = hamming_predict(req, active_sel);
    return {1'b0, res.result_word};
  endfunction

  // random requests: mostly in-range data and codewords with 0, 1 or 2 flips
  task automatic queue_random(int count);
    int          n, k, roll, a, b;
    logic        cmd;
    logic [31:0] operand;
    code_geometry(active_sel, n, k);
    for (int i = 0; i < count; i++) begin
      cmd  = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 12) begin
        // out of range, some bit at or above the field width set
        operand = $urandom |
                  (32'd1 << $urandom_range(31, (cmd == hc_pkg::CMD_ENCODE) ? k : n));
      end else if (cmd == hc_pkg::CMD_ENCODE) begin
        operand = $urandom & ((32'd1 << k) - 1);
      end else begin
        operand = codeword_of($urandom & ((32'd1 << k) - 1));
        roll    = $urandom_range(9);
        a       = $urandom_range(n - 1);
        b       = (a + $urandom_range(n - 1, 1)) % n;
        if (roll >= 3 && roll <= 7) begin
          operand ^= 32'd1 << a;
        end else if (roll == 8) begin
          operand ^= (32'd1 << a) | (32'd1 << b);
        end else if (roll == 9) begin
          operand = $urandom & ((32'd1 << n) - 1);
        end
      end
      queue_request(cmd, operand);
    end
  endtask

  // every queued request has come back as a result
  task automatic wait_drained();
    while (checked_count < queued_count || predicted_words.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_code_select(logic [1:0] sel);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sel;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    active_sel   = sel;
  endtask

  // request driver, predicts on acceptance
  always @(posedge clk_i) begin : drive_requests
    logic        next_valid;
    hc_pkg::in_t next_data;
    next_valid = in_valid_i;
    next_data  = in_data_i;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_words.push_back(hamming_predict(in_data_i, active_sel));
        next_valid = 1'b0;
        if ($urandom_range(99) < gap_pct) send_gap = $urandom_range(5, 1);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() != 0) begin
          next_data  = request_q.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_valid_i <= next_valid;
    in_data_i  <= next_data;
  end

  // result monitor and output stall bursts
  always @(posedge clk_i) begin : check_results
    hc_pkg::out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        checked_count++;
        if (predicted_words.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
          mismatch_count++;
        end else begin
          want = predicted_words.pop_front();
          if (out_data_o.result_word !== want.result_word) begin
            $display("%0t: result_word expected %h actual %h",
                     $time, want.result_word, out_data_o.result_word);
            mismatch_count++;
          end
          if (out_data_o.range_error !== want.range_error) begin
            $display("%0t: range_error expected %b actual %b",
                     $time, want.range_error, out_data_o.range_error);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(99) < stall_pct) stall_left = $urandom_range(5, 1);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus phases over all code selects, last phase without idling
  initial begin : run_phases
    logic [1:0] phase_sel[NUM_PHASES];
    int         phase_gap[NUM_PHASES];
    int         phase_stall[NUM_PHASES];
    phase_sel   = '{hc_pkg::CODE_7_4, hc_pkg::CODE_15_11, hc_pkg::CODE_31_26,
                    CODE_SEL_UNUSED, hc_pkg::CODE_15_11, hc_pkg::CODE_7_4,
                    hc_pkg::CODE_31_26};
    phase_gap   = '{30, 0, 45, 15, 60, 20, 0};
    phase_stall = '{25, 0, 40, 50, 10, 35, 0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_code_select(phase_sel[ph]);
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      // directed corners for the short code
      if (phase_sel[ph] == hc_pkg::CODE_7_4 && ph == 0) begin
        queue_request(hc_pkg::CMD_ENCODE, 32'h0);
        queue_request(hc_pkg::CMD_ENCODE, 32'hF);
        queue_request(hc_pkg::CMD_ENCODE, 32'h10);
        queue_request(hc_pkg::CMD_ENCODE, 32'hFFFF_FFFF);
        queue_request(hc_pkg::CMD_DECODE, 32'h0);
        queue_request(hc_pkg::CMD_DECODE, 32'h7F);
        queue_request(hc_pkg::CMD_DECODE, 32'h80);
        queue_request(hc_pkg::CMD_DECODE, 32'hFFFF_FFFF);
        queue_request(hc_pkg::CMD_DECODE, codeword_of(32'hB) ^ 32'h40);
        queue_request(hc_pkg::CMD_DECODE, codeword_of(32'hB) ^ 32'h01);
        queue_request(hc_pkg::CMD_DECODE, codeword_of(32'h6) ^ 32'h05);
      end
      // directed corners for the long code and the unused select
      if (phase_sel[ph] == hc_pkg::CODE_31_26 && ph == 2) begin
        queue_request(hc_pkg::CMD_ENCODE, 32'h03FF_FFFF);
        queue_request(hc_pkg::CMD_ENCODE, 32'h0400_0000);
        queue_request(hc_pkg::CMD_DECODE, 32'h7FFF_FFFF);
        queue_request(hc_pkg::CMD_DECODE, 32'h8000_0000);
        queue_request(hc_pkg::CMD_DECODE, codeword_of(32'h02AA_AAAA) ^ 32'h4000_0000);
        queue_request(hc_pkg::CMD_DECODE, codeword_of(32'h0155_5555) ^ 32'h0000_0001);
        queue_request(hc_pkg::CMD_DECODE, codeword_of(32'h0123_4567) ^ 32'h0000_0300);
      end
      if (phase_sel[ph] == CODE_SEL_UNUSED) begin
        queue_request(hc_pkg::CMD_ENCODE, 32'h03FF_FFFF);
        queue_request(hc_pkg::CMD_DECODE, 32'h7FFF_FFFF);
        queue_request(hc_pkg::CMD_ENCODE, 32'h0400_0000);
      end
      queue_random(50);
      // sender holds off until every result is back
      wait_drained();
      queue_random(50);
      wait_drained();
      repeat (4) @(posedge clk_i);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
